// ===== hdl/jsu_pkg.sv =====
// Shared types, codes and a helper function for the JSON string unescaper.
package jsu_pkg;

    // Character and field widths
    localparam int CHAR_WIDTH = 16;
    localparam int OUT_WIDTH  = 16;
    localparam int KIND_WIDTH = 2;
    localparam int PH_WIDTH   = 3;
    localparam int HEX_CNT_W  = 2;
    localparam int ACC_WIDTH  = 12;

    // Parser phases
    localparam logic [PH_WIDTH-1:0] PH_SKIP = 3'd0;
    localparam logic [PH_WIDTH-1:0] PH_STR  = 3'd1;
    localparam logic [PH_WIDTH-1:0] PH_ESC  = 3'd2;
    localparam logic [PH_WIDTH-1:0] PH_HEX  = 3'd3;
    localparam logic [PH_WIDTH-1:0] PH_WAIT = 3'd4;

    // Result kinds
    localparam logic [KIND_WIDTH-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_ERR  = 2'd2;

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] CH_QUOTE = CHAR_WIDTH'(8'h22);
    localparam logic [CHAR_WIDTH-1:0] CH_BSLASH = CHAR_WIDTH'(8'h5C);
    localparam logic [CHAR_WIDTH-1:0] CH_B     = CHAR_WIDTH'(8'h62);
    localparam logic [CHAR_WIDTH-1:0] CH_F     = CHAR_WIDTH'(8'h66);
    localparam logic [CHAR_WIDTH-1:0] CH_N     = CHAR_WIDTH'(8'h6E);
    localparam logic [CHAR_WIDTH-1:0] CH_R     = CHAR_WIDTH'(8'h72);
    localparam logic [CHAR_WIDTH-1:0] CH_T     = CHAR_WIDTH'(8'h74);
    localparam logic [CHAR_WIDTH-1:0] CH_U     = CHAR_WIDTH'(8'h75);
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = CHAR_WIDTH'(8'h09);
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = CHAR_WIDTH'(8'h0D);
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = CHAR_WIDTH'(8'h20);

    // Decoded control characters
    localparam logic [OUT_WIDTH-1:0] DEC_BS = OUT_WIDTH'(8'h08);
    localparam logic [OUT_WIDTH-1:0] DEC_FF = OUT_WIDTH'(8'h0C);
    localparam logic [OUT_WIDTH-1:0] DEC_LF = OUT_WIDTH'(8'h0A);
    localparam logic [OUT_WIDTH-1:0] DEC_CR = OUT_WIDTH'(8'h0D);
    localparam logic [OUT_WIDTH-1:0] DEC_HT = OUT_WIDTH'(8'h09);

    // Parser state carried between characters
    typedef struct packed {
        logic [PH_WIDTH-1:0]  phase;
        logic [HEX_CNT_W-1:0] hex_cnt;
        logic [ACC_WIDTH-1:0] acc;
    } parse_state_t;

    // One result item plus its presence flag
    typedef struct packed {
        logic                  valid;
        logic [OUT_WIDTH-1:0]  out_char;
        logic [KIND_WIDTH-1:0] kind;
        logic                  last;
    } result_t;

    // Hex digit value: bit 4 flags a legal digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_value(input logic [CHAR_WIDTH-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CHAR_WIDTH'(8'h30) && c <= CHAR_WIDTH'(8'h39))
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= CHAR_WIDTH'(8'h61) && c <= CHAR_WIDTH'(8'h66)) ||
                 (c >= CHAR_WIDTH'(8'h41) && c <= CHAR_WIDTH'(8'h46)))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hdl/jsu_if.sv =====
// Valid/ready channel interfaces for the input characters and the results.
interface jsu_in_if;
    logic                            valid;
    logic                            ready;
    logic [jsu_pkg::CHAR_WIDTH-1:0]  char_code;
    logic                            end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface jsu_out_if;
    logic                            valid;
    logic                            ready;
    logic [jsu_pkg::OUT_WIDTH-1:0]   out_char;
    logic [jsu_pkg::KIND_WIDTH-1:0]  kind;
    logic                            last;

    modport source (output valid, output out_char, output kind, output last, input ready);
    modport sink   (input valid, input out_char, input kind, input last, output ready);
endinterface

// ===== hdl/jsu_decode.sv =====
// Combinational next-state and result decode for one character.
module jsu_decode (
    input  jsu_pkg::parse_state_t              cur,
    input  logic [jsu_pkg::CHAR_WIDTH-1:0]     c,
    input  logic                               end_flag,
    output jsu_pkg::parse_state_t              nxt,
    output jsu_pkg::result_t                   res
);

    logic [4:0] hv;

    assign hv = jsu_pkg::hex_value(c);

    // Walk the phase rules for one character
    always_comb
    begin
        nxt          = cur;
        res.valid    = 1'b0;
        res.out_char = '0;
        res.kind     = jsu_pkg::KIND_CHAR;
        res.last     = 1'b0;

        case (cur.phase)
            jsu_pkg::PH_SKIP:
            begin
                if (end_flag)
                begin
                    nxt       = '{jsu_pkg::PH_SKIP, '0, '0};
                    res.valid = 1'b1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.last  = 1'b1;
                end
                else if (c == jsu_pkg::CH_QUOTE)
                begin
                    nxt.phase = jsu_pkg::PH_STR;
                end
                else if (!((c >= jsu_pkg::CH_TAB && c <= jsu_pkg::CH_CR) ||
                           c == jsu_pkg::CH_SPACE))
                begin
                    nxt       = '{jsu_pkg::PH_WAIT, '0, '0};
                    res.valid = 1'b1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.last  = 1'b1;
                end
            end
            jsu_pkg::PH_STR:
            begin
                if (c == jsu_pkg::CH_QUOTE)
                begin
                    nxt       = '{(end_flag ? jsu_pkg::PH_SKIP : jsu_pkg::PH_WAIT), '0, '0};
                    res.valid = 1'b1;
                    res.kind  = jsu_pkg::KIND_DONE;
                    res.last  = 1'b1;
                end
                else if (end_flag)
                begin
                    nxt       = '{jsu_pkg::PH_SKIP, '0, '0};
                    res.valid = 1'b1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.last  = 1'b1;
                end
                else if (c == jsu_pkg::CH_BSLASH)
                begin
                    nxt.phase = jsu_pkg::PH_ESC;
                end
                else
                begin
                    res.valid    = 1'b1;
                    res.out_char = jsu_pkg::OUT_WIDTH'(c);
                end
            end
            jsu_pkg::PH_ESC:
            begin
                if (end_flag)
                begin
                    nxt       = '{jsu_pkg::PH_SKIP, '0, '0};
                    res.valid = 1'b1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.last  = 1'b1;
                end
                else if (c == jsu_pkg::CH_U)
                begin
                    nxt = '{jsu_pkg::PH_HEX, '0, '0};
                end
                else
                begin
                    nxt.phase = jsu_pkg::PH_STR;
                    res.valid = 1'b1;
                    if (c == jsu_pkg::CH_B)
                    begin
                        res.out_char = jsu_pkg::DEC_BS;
                    end
                    else if (c == jsu_pkg::CH_F)
                    begin
                        res.out_char = jsu_pkg::DEC_FF;
                    end
                    else if (c == jsu_pkg::CH_N)
                    begin
                        res.out_char = jsu_pkg::DEC_LF;
                    end
                    else if (c == jsu_pkg::CH_R)
                    begin
                        res.out_char = jsu_pkg::DEC_CR;
                    end
                    else if (c == jsu_pkg::CH_T)
                    begin
                        res.out_char = jsu_pkg::DEC_HT;
                    end
                    else
                    begin
                        res.out_char = jsu_pkg::OUT_WIDTH'(c);
                    end
                end
            end
            jsu_pkg::PH_HEX:
            begin
                if (end_flag)
                begin
                    nxt       = '{jsu_pkg::PH_SKIP, '0, '0};
                    res.valid = 1'b1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.last  = 1'b1;
                end
                else if (!hv[4])
                begin
                    nxt       = '{jsu_pkg::PH_WAIT, '0, '0};
                    res.valid = 1'b1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.last  = 1'b1;
                end
                else if (cur.hex_cnt != 2'd3)
                begin
                    // Shift in one more digit
                    nxt.acc     = {cur.acc[jsu_pkg::ACC_WIDTH-5:0], hv[3:0]};
                    nxt.hex_cnt = cur.hex_cnt + 2'd1;
                end
                else
                begin
                    nxt          = '{jsu_pkg::PH_STR, '0, '0};
                    res.valid    = 1'b1;
                    res.out_char = {cur.acc, hv[3:0]};
                end
            end
            default:
            begin
                // Waiting for the end of the message; unused codes act the same
                if (end_flag)
                begin
                    nxt = '{jsu_pkg::PH_SKIP, '0, '0};
                end
            end
        endcase
    end

endmodule

// ===== hdl/json_string_unescaper_top.sv =====
// Top level of the JSON string unescaper: input register, decode, result register.
// Takes one wide character per cycle on in_chan and gives at most one result per
// character on out_chan (a decoded character, string done, or error). Throughput is
// one character every cycle with no stall as long as out_chan takes its transfers;
// each character passes through the input register and then the result register.
// The parser state updates once per character, in the same cycle that character
// moves from the input register into the result register. After reset the block
// skips whitespace and waits for an opening quote.
module json_string_unescaper_top (
    input  logic         clk,
    input  logic         rst_n,
    jsu_in_if.sink       in_chan,
    jsu_out_if.source    out_chan
);

    logic                            in_valid_reg;
    logic [jsu_pkg::CHAR_WIDTH-1:0]  in_char_reg;
    logic                            in_end_reg;
    jsu_pkg::parse_state_t           state_reg;
    jsu_pkg::parse_state_t           state_next;
    jsu_pkg::result_t                res_reg;
    jsu_pkg::result_t                res_next;
    logic                            advance;
    logic                            consume;

    // The result register frees up when empty or when its transfer completes
    assign advance       = !res_reg.valid || out_chan.ready;
    assign consume       = in_valid_reg && advance;
    assign in_chan.ready = !in_valid_reg || advance;

    jsu_decode u_decode (
        .cur      (state_reg),
        .c        (in_char_reg),
        .end_flag (in_end_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    // Hold the accepted character until decode moves it on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            in_valid_reg <= in_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.ready && in_chan.valid)
        begin
            in_char_reg <= in_chan.char_code;
            in_end_reg  <= in_chan.end_of_text;
        end
    end

    // Advance parser state once per consumed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{jsu_pkg::PH_SKIP, '0, '0};
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    // Load the result register; drop the slot when nothing is produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                res_reg.valid <= in_valid_reg && res_next.valid;
            end
            if (consume && res_next.valid)
            begin
                res_reg.out_char <= res_next.out_char;
                res_reg.kind     <= res_next.kind;
                res_reg.last     <= res_next.last;
            end
        end
    end

    assign out_chan.valid    = res_reg.valid;
    assign out_chan.out_char = res_reg.out_char;
    assign out_chan.kind     = res_reg.kind;
    assign out_chan.last     = res_reg.last;

endmodule
